// File: hdl/lca_pkg.sv
// ----------------------------------------------------------------------------
// lca_pkg
// Shared types, constants and helpers of the binary lifting ancestor engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lca_pkg;

    localparam int NODE_W      = 10;
    localparam int LVL_W       = 4;
    localparam int JUMP_LEVELS = 16;
    localparam int MAX_NODES   = 1024;
    localparam int JADDR_W     = NODE_W + LVL_W;
    localparam int JMP_DEPTH   = MAX_NODES * JUMP_LEVELS;
    // step (up to 2**(JUMP_LEVELS-1)) plus a depth
    localparam int CMP_W       = JUMP_LEVELS + 1;

    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 16;
    localparam int APB_DATA_W  = 32;
    localparam int PADDR_W     = 3;
    localparam int REG_IDX_W   = PADDR_W - 2;

    typedef logic [NODE_W-1:0]     t_node;
    typedef logic [LVL_W-1:0]      t_lvl;
    typedef logic [JADDR_W-1:0]    t_jaddr;
    typedef logic [IN_TUSER_W-1:0] t_func;
    typedef logic [REG_IDX_W-1:0]  t_reg_idx;

    localparam t_func FUNC_LOAD  = 2'd0;
    localparam t_func FUNC_BUILD = 2'd1;
    localparam t_func FUNC_QUERY = 2'd2;

    localparam t_reg_idx REG_NODE_COUNT = 1'b0;

    localparam t_node NODE_NONE  = '0;
    localparam t_node NODE_ROOT  = NODE_W'(1);
    localparam t_lvl  LVL_ZERO   = '0;
    localparam t_lvl  LVL_FIRST  = LVL_W'(1);
    localparam t_lvl  LVL_LAST   = LVL_W'(JUMP_LEVELS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_B_RD1,
        S_B_RD2,
        S_B_WR,
        S_Q_DB,
        S_Q_SW,
        S_Q_UP,
        S_Q_DN,
        S_Q_FIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic   dep_we;
        t_node  dep_waddr;
        t_node  dep_wdata;
        t_node  dep_raddr;
        logic   jmp_we;
        t_jaddr jmp_waddr;
        t_node  jmp_wdata;
        t_jaddr jmp_raddr_a;
        t_jaddr jmp_raddr_b;
    } t_mem_req;

    typedef struct packed {
        t_node dep_rdata;
        t_node jmp_rdata_a;
        t_node jmp_rdata_b;
    } t_mem_rsp;

    function automatic t_jaddr jaddr(input t_node node, input t_lvl lvl);
        return {node, lvl};
    endfunction

    // index of the highest set bit, clamped to the top jump level
    function automatic t_lvl floor_log2(input t_node d);
        t_lvl r;
        r = LVL_ZERO;
        for (int i = 0; i < NODE_W; i++) begin
            if (d[i]) begin
                r = (i > JUMP_LEVELS - 1) ? LVL_LAST : LVL_W'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/tree_lca_binary_lifting.sv
// ----------------------------------------------------------------------------
// tree_lca_binary_lifting
// Lowest common ancestor engine by binary lifting over a jump table memory.
// ----------------------------------------------------------------------------
// load and unused codes go from accept straight to the result beat; query
//   lifting runs from level L down to 0, L = floor(log2) of the deeper node's depth,
//   one jump table read per lifting step
// build: three memory accesses per table entry
// one item at a time; the next item is taken while a result beat waits
// reset: synchronous, active low; node_count returns to 1, memories keep data
`default_nettype none

module tree_lca_binary_lifting (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // apb register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lca_pkg::PADDR_W-1:0]        paddr,
    input  logic [lca_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lca_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    // input beats
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // node_a[9:0], node_b[19:10], depth[29:20], zero fill
    input  logic [lca_pkg::IN_TDATA_W-1:0]     s_tdata,
    // func[1:0]
    input  logic [lca_pkg::IN_TUSER_W-1:0]     s_tuser,
    // result beats
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // ancestor[9:0], zero fill
    output logic [lca_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import lca_pkg::*;

    t_node    r_node_count;
    t_reg_idx reg_idx;
    logic     reg_hit;
    t_mem_req mem_req;
    t_mem_rsp mem_rsp;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign reg_hit = (reg_idx == REG_NODE_COUNT);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? APB_DATA_W'(r_node_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_ROOT;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_node_count <= pwdata[NODE_W-1:0];
        end
    end

    lca_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_node_count (r_node_count),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .o_req        (mem_req),
        .i_rsp        (mem_rsp)
    );

    lca_store u_store (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_rsp (mem_rsp)
    );

endmodule

`default_nettype wire

// File: hdl/lca_store.sv
// ----------------------------------------------------------------------------
// lca_store
// Depth memory and jump table memory, with registered synchronous reads;
// node zero reads as none.
// ----------------------------------------------------------------------------
`default_nettype none

module lca_store (
    input  logic              i_clk,
    input  lca_pkg::t_mem_req i_req,
    output lca_pkg::t_mem_rsp o_rsp
);
    import lca_pkg::*;

    t_node r_dep_mem [MAX_NODES];
    t_node r_jmp_mem [JMP_DEPTH];

    t_node r_dep_rd;
    t_node r_jmp_rd_a;
    t_node r_jmp_rd_b;
    logic  r_dep_zero;
    logic  r_jmp_zero_a;
    logic  r_jmp_zero_b;

    always_ff @(posedge i_clk) begin
        if (i_req.dep_we) begin
            r_dep_mem[i_req.dep_waddr] <= i_req.dep_wdata;
        end
        r_dep_rd   <= r_dep_mem[i_req.dep_raddr];
        r_dep_zero <= (i_req.dep_raddr == NODE_NONE);
    end

    always_ff @(posedge i_clk) begin
        if (i_req.jmp_we) begin
            r_jmp_mem[i_req.jmp_waddr] <= i_req.jmp_wdata;
        end
        r_jmp_rd_a   <= r_jmp_mem[i_req.jmp_raddr_a];
        r_jmp_rd_b   <= r_jmp_mem[i_req.jmp_raddr_b];
        r_jmp_zero_a <= (i_req.jmp_raddr_a[JADDR_W-1:LVL_W] == NODE_NONE);
        r_jmp_zero_b <= (i_req.jmp_raddr_b[JADDR_W-1:LVL_W] == NODE_NONE);
    end

    // node zero is never stored, it has depth 0 and no ancestors
    assign o_rsp.dep_rdata   = r_dep_zero   ? NODE_NONE : r_dep_rd;
    assign o_rsp.jmp_rdata_a = r_jmp_zero_a ? NODE_NONE : r_jmp_rd_a;
    assign o_rsp.jmp_rdata_b = r_jmp_zero_b ? NODE_NONE : r_jmp_rd_b;

endmodule

`default_nettype wire

// File: hdl/lca_ctrl.sv
// ----------------------------------------------------------------------------
// lca_ctrl
// Sequencer for load, table build and ancestor query, with the result
// register on the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module lca_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lca_pkg::t_node                      i_node_count,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lca_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  lca_pkg::t_func                      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lca_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output lca_pkg::t_mem_req                   o_req,
    input  lca_pkg::t_mem_rsp                   i_rsp
);
    import lca_pkg::*;

    t_state r_state, n_state;
    t_node  r_a, n_a;
    t_node  r_b, n_b;
    t_node  r_da, n_da;
    t_node  r_db, n_db;
    t_lvl   r_lvl, n_lvl;
    t_lvl   r_top, n_top;
    t_node  r_node, n_node;
    t_node  r_res, n_res;
    logic   r_out_valid, n_out_valid;
    t_node  r_out_data, n_out_data;

    t_node            in_a;
    t_node            in_b;
    t_node            in_d;
    t_node            sw_a;
    t_node            sw_b;
    t_node            sw_da;
    t_node            sw_db;
    t_lvl             sw_top;
    logic [CMP_W-1:0] up_step;
    logic             up_lift;
    t_node            up_a;
    logic             dn_move;
    t_node            dn_a;
    t_node            dn_b;
    t_lvl             lvl_dec;

    assign in_a = s_tdata[NODE_W-1:0];
    assign in_b = s_tdata[2*NODE_W-1:NODE_W];
    assign in_d = s_tdata[3*NODE_W-1:2*NODE_W];

    // deeper node goes first
    always_comb begin
        if (r_da < i_rsp.dep_rdata) begin
            sw_a  = r_b;
            sw_b  = r_a;
            sw_da = i_rsp.dep_rdata;
            sw_db = r_da;
        end else begin
            sw_a  = r_a;
            sw_b  = r_b;
            sw_da = r_da;
            sw_db = i_rsp.dep_rdata;
        end
    end

    assign sw_top  = floor_log2(sw_da);
    assign lvl_dec = r_lvl - LVL_FIRST;

    // lift when the depth after the step stays at or above the other node's depth
    assign up_step = CMP_W'(1) << r_lvl;
    assign up_lift = CMP_W'(i_rsp.dep_rdata) >= (up_step + CMP_W'(r_db));
    assign up_a    = up_lift ? i_rsp.jmp_rdata_a : r_a;

    assign dn_move = (i_rsp.jmp_rdata_a != NODE_NONE) &&
                     (i_rsp.jmp_rdata_a != i_rsp.jmp_rdata_b);
    assign dn_a    = dn_move ? i_rsp.jmp_rdata_a : r_a;
    assign dn_b    = dn_move ? i_rsp.jmp_rdata_b : r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a        <= n_a;
        r_b        <= n_b;
        r_da       <= n_da;
        r_db       <= n_db;
        r_lvl      <= n_lvl;
        r_top      <= n_top;
        r_node     <= n_node;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    always_comb begin
        n_state     = r_state;
        n_a         = r_a;
        n_b         = r_b;
        n_da        = r_da;
        n_db        = r_db;
        n_lvl       = r_lvl;
        n_top       = r_top;
        n_node      = r_node;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        o_req       = '0;
        s_tready    = 1'b0;

        if (r_out_valid && m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    n_res = NODE_NONE;
                    case (s_tuser)
                        FUNC_LOAD: begin
                            if (in_a != NODE_NONE) begin
                                o_req.dep_we    = 1'b1;
                                o_req.dep_waddr = in_a;
                                o_req.dep_wdata = in_d;
                                o_req.jmp_we    = 1'b1;
                                o_req.jmp_waddr = jaddr(in_a, LVL_ZERO);
                                o_req.jmp_wdata = in_b;
                            end
                            n_state = S_DONE;
                        end
                        FUNC_BUILD: begin
                            n_node  = NODE_ROOT;
                            n_lvl   = LVL_FIRST;
                            n_state = (i_node_count == NODE_NONE) ? S_DONE : S_B_RD1;
                        end
                        FUNC_QUERY: begin
                            n_a             = in_a;
                            n_b             = in_b;
                            o_req.dep_raddr = in_a;
                            n_state         = S_Q_DB;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_B_RD1: begin
                o_req.jmp_raddr_a = jaddr(r_node, lvl_dec);
                n_state           = S_B_RD2;
            end
            S_B_RD2: begin
                // a none midpoint reads back as none
                o_req.jmp_raddr_a = jaddr(i_rsp.jmp_rdata_a, lvl_dec);
                n_state           = S_B_WR;
            end
            S_B_WR: begin
                o_req.jmp_we    = 1'b1;
                o_req.jmp_waddr = jaddr(r_node, r_lvl);
                o_req.jmp_wdata = i_rsp.jmp_rdata_a;
                n_state         = S_B_RD1;
                if (r_node == i_node_count) begin
                    n_node = NODE_ROOT;
                    if (r_lvl == LVL_LAST) begin
                        n_state = S_DONE;
                    end else begin
                        n_lvl = r_lvl + LVL_FIRST;
                    end
                end else begin
                    n_node = r_node + NODE_W'(1);
                end
            end
            S_Q_DB: begin
                n_da            = i_rsp.dep_rdata;
                o_req.dep_raddr = r_b;
                n_state         = S_Q_SW;
            end
            S_Q_SW: begin
                n_a   = sw_a;
                n_b   = sw_b;
                n_db  = sw_db;
                n_top = sw_top;
                n_lvl = sw_top;
                if (sw_da == NODE_NONE) begin
                    // no lifting levels at all
                    if (sw_a == sw_b) begin
                        n_res   = sw_a;
                        n_state = S_DONE;
                    end else begin
                        o_req.jmp_raddr_a = jaddr(sw_a, LVL_ZERO);
                        n_state           = S_Q_FIN;
                    end
                end else begin
                    o_req.dep_raddr   = sw_a;
                    o_req.jmp_raddr_a = jaddr(sw_a, sw_top);
                    n_state           = S_Q_UP;
                end
            end
            S_Q_UP: begin
                n_a = up_a;
                if (r_lvl == LVL_ZERO) begin
                    if (up_a == r_b) begin
                        n_res   = up_a;
                        n_state = S_DONE;
                    end else begin
                        o_req.jmp_raddr_a = jaddr(up_a, r_top);
                        o_req.jmp_raddr_b = jaddr(r_b, r_top);
                        n_lvl             = r_top;
                        n_state           = S_Q_DN;
                    end
                end else begin
                    o_req.dep_raddr   = up_a;
                    o_req.jmp_raddr_a = jaddr(up_a, lvl_dec);
                    n_lvl             = lvl_dec;
                end
            end
            S_Q_DN: begin
                n_a = dn_a;
                n_b = dn_b;
                if (r_lvl == LVL_ZERO) begin
                    o_req.jmp_raddr_a = jaddr(dn_a, LVL_ZERO);
                    n_state           = S_Q_FIN;
                end else begin
                    o_req.jmp_raddr_a = jaddr(dn_a, lvl_dec);
                    o_req.jmp_raddr_b = jaddr(dn_b, lvl_dec);
                    n_lvl             = lvl_dec;
                end
            end
            S_Q_FIN: begin
                n_res   = i_rsp.jmp_rdata_a;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = OUT_TDATA_W'(r_out_data);

endmodule

`default_nettype wire

// File: hdl/lca_checker.sv
// ----------------------------------------------------------------------------
// lca_checker
// Port level checks of the ancestor engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lca_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               psel,
    input logic                               penable,
    input logic                               pwrite,
    input logic [lca_pkg::PADDR_W-1:0]        paddr,
    input logic [lca_pkg::APB_DATA_W-1:0]     pwdata,
    input logic [lca_pkg::APB_DATA_W-1:0]     prdata,
    input logic                               pready,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [lca_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import lca_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped or changed while stalled");

    // one item in flight: an accepted beat closes the input side
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is in work");

    // a new result follows work, never an idle input side
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without work in progress");

    // node count reads back what was written
    a_reg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready && (paddr[PADDR_W-1:2] == REG_NODE_COUNT)
        |=> (paddr[PADDR_W-1:2] != REG_NODE_COUNT) ||
            (prdata[NODE_W-1:0] == $past(pwdata[NODE_W-1:0])))
        else $error("node count readback mismatch");

endmodule

bind tree_lca_binary_lifting lca_checker u_lca_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the binary lifting ancestor engine. Random trees are
// loaded node by node, the jump table is built, and ancestor queries are
// checked beat by beat against a predictor that tracks depth, jump table and
// node count. Sizes of the tree change between phases over the APB port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import lca_pkg::*;

    localparam t_func FUNC_UNUSED = 2'd3;
    localparam int    WDOG_LIMIT  = 200000;
    localparam int    ITEM_BUDGET = 550;

    typedef struct packed {
        t_func func;
        t_node node_a;
        t_node node_b;
        t_node depth;
    } t_tree_op;

    logic                   i_clk    = 1'b0;
    logic                   i_rst_n  = 1'b0;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [PADDR_W-1:0]     paddr    = '0;
    logic [APB_DATA_W-1:0]  pwdata   = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // node_a[9:0], node_b[19:10], depth[29:20], zero fill
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    // func[1:0]
    logic [IN_TUSER_W-1:0]  s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // ancestor[9:0], zero fill
    logic [OUT_TDATA_W-1:0] m_tdata;

    t_tree_op tree_ops[$];
    t_node    ancestor_q[$];
    t_tree_op cur_op;

    // predicted engine state
    t_node depth_mem [MAX_NODES];
    t_node jump_mem  [MAX_NODES][JUMP_LEVELS];
    int    node_count_cfg = 1;

    int src_gap       = 0;
    int sink_gap      = 0;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int idle_cycles   = 0;
    int errors        = 0;
    int counted       = 0;
    bit calm          = 1'b0;

    tree_lca_binary_lifting dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic t_node depth_at(input t_node n);
        return (n == NODE_NONE) ? NODE_NONE : depth_mem[n];
    endfunction

    function automatic t_node jump_at(input t_node n, input int lvl);
        if (n == NODE_NONE || lvl >= JUMP_LEVELS) begin
            return NODE_NONE;
        end
        return jump_mem[n][lvl];
    endfunction

    function automatic void rebuild_jumps();
        t_node mid;
        for (int lvl = 1; lvl < JUMP_LEVELS; lvl++) begin
            for (int n = 1; n <= node_count_cfg && n < MAX_NODES; n++) begin
                mid = jump_mem[n][lvl-1];
                jump_mem[n][lvl] = (mid != NODE_NONE) ? jump_at(mid, lvl - 1) : NODE_NONE;
            end
        end
    endfunction

    function automatic t_node lowest_common(input t_node a, input t_node b);
        t_node       x, y, tmp, ja, jb;
        int          top, i;
        int unsigned dx, du, step;
        x = a;
        y = b;
        if (depth_at(x) < depth_at(y)) begin
            tmp = x;
            x   = y;
            y   = tmp;
        end
        dx  = depth_at(x);
        top = -1;
        while (top + 1 < 31 && (32'd1 << (top + 1)) <= dx) top++;
        if (top > JUMP_LEVELS - 1) top = JUMP_LEVELS - 1;
        // lift the deeper node up to the other one's depth
        for (i = top; i >= 0; i--) begin
            step = 32'd1 << i;
            du   = depth_at(x);
            if (du >= step && du - step >= depth_at(y)) x = jump_at(x, i);
        end
        if (x == y) return x;
        for (i = top; i >= 0; i--) begin
            ja = jump_at(x, i);
            jb = jump_at(y, i);
            if (ja != NODE_NONE && ja != jb) begin
                x = ja;
                y = jb;
            end
        end
        return jump_at(x, 0);
    endfunction

    // applies one accepted beat to the predicted state, returns its answer
    function automatic t_node ancestor_after(input t_tree_op op);
        case (op.func)
            FUNC_LOAD: begin
                if (op.node_a != NODE_NONE) begin
                    depth_mem[op.node_a]   = op.depth;
                    jump_mem[op.node_a][0] = op.node_b;
                end
                return NODE_NONE;
            end
            FUNC_BUILD: begin
                rebuild_jumps();
                return NODE_NONE;
            end
            FUNC_QUERY: return lowest_common(op.node_a, op.node_b);
            default:    return NODE_NONE;
        endcase
    endfunction

    // ---------------- stimulus helpers ----------------
    task automatic push_op(input t_func f, input int a, input int b, input int d);
        t_tree_op op;
        op.func   = f;
        op.node_a = t_node'(a);
        op.node_b = t_node'(b);
        op.depth  = t_node'(d);
        tree_ops.insert(tree_ops.size(), op);
        counted++;
    endtask

    // beats the engine only answers with zero
    task automatic push_noise();
        if ($urandom_range(0, 1) == 0) begin
            push_op(FUNC_LOAD, 0, $urandom_range(0, 1023), $urandom_range(0, 1023));
        end else begin
            push_op(FUNC_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 1023),
                    $urandom_range(0, 1023));
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (tree_ops.size() != 0 || s_tvalid || ancestor_q.size() != 0);
    endtask

    task automatic set_node_count(input int value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_NODE_COUNT, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        node_count_cfg = value;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        if (prdata !== APB_DATA_W'(value)) report_mismatch("node_count readback", prdata, value);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic pick_idling();
        int pct [3] = '{0, 12, 35};
        src_idle_pct  = calm ? 0 : pct[$urandom_range(0, 2)];
        sink_idle_pct = calm ? 0 : pct[$urandom_range(0, 2)];
    endtask

    // loads a random tree of n nodes, builds, then queries with some reloads, rebuilds and noise
    task automatic random_phase(input int n, input int chain_pct, input int n_queries);
        int dep [MAX_NODES];
        int v, par, x, y, k, r;
        set_node_count(n);
        pick_idling();
        for (v = 1; v <= n; v++) begin
            if (v == 1) par = 0;
            else if ($urandom_range(0, 99) < chain_pct) par = v - 1;
            else par = $urandom_range(1, v - 1);
            dep[v] = (par == 0) ? 0 : dep[par] + 1;
            if ($urandom_range(0, 99) < 4) push_op(FUNC_LOAD, v, par, $urandom_range(0, 1023));
            else push_op(FUNC_LOAD, v, par, dep[v]);
            if ($urandom_range(0, 99) < 3) push_noise();
        end
        push_op(FUNC_BUILD, $urandom_range(0, 1023), $urandom_range(0, 1023),
                $urandom_range(0, 1023));
        for (k = 0; k < n_queries; k++) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
                // parent changed after the build, upper levels go stale
                x = $urandom_range(1, n);
                push_op(FUNC_LOAD, x, $urandom_range(0, x - 1), $urandom_range(0, 1023));
            end else if (r < 6) begin
                push_op(FUNC_BUILD, 0, 0, 0);
            end else if (r < 9) begin
                push_noise();
            end else begin
                x = $urandom_range(1, n);
                y = $urandom_range(1, n);
                if ($urandom_range(0, 19) == 0) x = 0;
                if ($urandom_range(0, 9) == 0) y = x;
                push_op(FUNC_QUERY, x, y, $urandom_range(0, 1023));
            end
        end
        wait_drained();
    endtask

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        t_tree_op nxt;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            src_gap  <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                ancestor_q.insert(ancestor_q.size(), ancestor_after(cur_op));
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap == 0 && tree_ops.size() != 0 &&
                    $urandom_range(0, 99) >= src_idle_pct) begin
                    nxt = tree_ops.pop_front();
                    cur_op   <= nxt;
                    s_tvalid <= 1'b1;
                    s_tdata  <= {2'b00, nxt.depth, nxt.node_b, nxt.node_a};
                    s_tuser  <= nxt.func;
                end else begin
                    s_tvalid <= 1'b0;
                    if (src_gap != 0) src_gap <= src_gap - 1;
                    else if (tree_ops.size() != 0) src_gap <= $urandom_range(0, 4);
                end
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        t_node want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            sink_gap <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (ancestor_q.size() == 0) begin
                    report_mismatch("unexpected result beat", m_tdata[NODE_W-1:0], 0);
                end else begin
                    want = ancestor_q.pop_front();
                    if (m_tdata[NODE_W-1:0] !== want) begin
                        report_mismatch("ancestor", m_tdata[NODE_W-1:0], want);
                    end
                end
            end
            if (sink_gap != 0) begin
                sink_gap <= sink_gap - 1;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 99) < sink_idle_pct) begin
                sink_gap <= $urandom_range(0, 4);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ---------------- test sequence ----------------
    initial begin
        foreach (depth_mem[n]) depth_mem[n] = NODE_NONE;
        foreach (jump_mem[n, l]) jump_mem[n][l] = NODE_NONE;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single root: the root is its own ancestor, node zero has none
        set_node_count(1);
        push_op(FUNC_LOAD, 1, 0, 0);
        push_op(FUNC_BUILD, 0, 0, 0);
        push_op(FUNC_QUERY, 1, 1, 0);
        push_op(FUNC_QUERY, 0, 1, 1023);
        wait_drained();

        // small known tree: 1 - {2, 3}, 2 - {4, 5}, 3 - 6, 6 - 7
        set_node_count(7);
        sink_idle_pct = 30;
        push_op(FUNC_LOAD, 1, 0, 0);
        push_op(FUNC_LOAD, 2, 1, 1);
        push_op(FUNC_LOAD, 3, 1, 1);
        push_op(FUNC_LOAD, 4, 2, 2);
        push_op(FUNC_LOAD, 5, 2, 2);
        push_op(FUNC_LOAD, 6, 3, 2);
        push_op(FUNC_LOAD, 7, 6, 3);
        push_op(FUNC_LOAD, 0, 1023, 1023);
        push_op(FUNC_UNUSED, 1023, 1023, 1023);
        push_op(FUNC_BUILD, 0, 0, 0);
        push_op(FUNC_QUERY, 4, 5, 0);
        push_op(FUNC_QUERY, 5, 4, 0);
        push_op(FUNC_QUERY, 7, 4, 0);
        push_op(FUNC_QUERY, 7, 6, 0);
        push_op(FUNC_QUERY, 3, 7, 0);
        push_op(FUNC_QUERY, 2, 2, 0);
        push_op(FUNC_QUERY, 0, 5, 0);
        // deepest possible depth on a shallow chain
        push_op(FUNC_LOAD, 7, 6, 1023);
        push_op(FUNC_QUERY, 7, 1, 0);
        push_op(FUNC_QUERY, 5, 7, 0);
        wait_drained();

        // zero nodes in use: build leaves the table alone
        set_node_count(0);
        push_op(FUNC_BUILD, 0, 0, 0);
        push_op(FUNC_QUERY, 4, 5, 0);
        wait_drained();

        // larger tree, mostly one long chain
        random_phase(200, 92, 40);

        while (counted < ITEM_BUDGET) begin
            calm = (counted > ITEM_BUDGET - 120);
            random_phase(($urandom_range(0, 3) == 0) ? $urandom_range(31, 60)
                                                     : $urandom_range(2, 30),
                         $urandom_range(0, 100), $urandom_range(15, 40));
        end

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
